[hdl/dag_shortest_path_defines.svh]
// Assertion macros shared by the checker of the shortest-path block.
// No dependencies.
`ifndef DAG_SHORTEST_PATH_DEFINES_SVH
`define DAG_SHORTEST_PATH_DEFINES_SVH
// implication checked on every edge out of reset
`define DSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define DSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hdl/dsp_pkg.sv]
// Package for the DAG shortest-path block: sizes, types and state codes.
// No dependencies.
`default_nettype none
package dsp_pkg;
  localparam int MaxVertices = 16;
  localparam int WeightBits  = 16;
  localparam int VBits       = $clog2(MaxVertices);
  localparam int CntBits     = VBits + 1;
  localparam int AddrBits    = 2 * VBits;
  localparam int DistBits    = 24;
  localparam int RegVertexCount  = 0;
  localparam int RegSourceVertex = 1;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_CLR, S_DFS_TOP, S_DFS_RD, S_DFS_EVAL,
    S_REL_POP, S_REL_RD, S_REL_EVAL, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    C_NONE, C_LOAD, C_INIT, C_CLR, C_DFS_TOP, C_DFS_RD, C_DFS_EVAL,
    C_REL_POP, C_REL_RD, C_REL_EVAL, C_EMIT
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic clr_done;
    logic sp_empty;
    logic frame_done;
    logic order_empty;
    logic cur_reach;
    logic col_done;
    logic emit_done;
    logic out_full;
  } status_t;
endpackage
`default_nettype wire

[hdl/dsp_if.sv]
// Valid/ready channel interfaces: edge input, distance result, register write.
// Depends on dsp_pkg.
`default_nettype none
interface dsp_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic signed [dsp_pkg::WeightBits-1:0] edge_weight;
  modport source (output valid, output edge_weight, input ready);
  modport sink (input valid, input edge_weight, output ready);
endinterface

interface dsp_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [3:0] vertex_index;
  logic signed [23:0] distance;
  logic reachable;
  logic last_result;
  modport source (output valid, output vertex_index, output distance, output reachable,
                  output last_result, input ready);
  modport sink (input valid, input vertex_index, input distance, input reachable,
                input last_result, output ready);
endinterface

interface dsp_cfg_if (input wire logic clk);
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [4:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/dsp_ctrl.sv]
// Controller state machine for the shortest-path block.
// Depends on dsp_pkg; drives commands to dsp_datapath.
`default_nettype none
module dsp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire dsp_pkg::status_t status,
  output dsp_pkg::cmd_t         cmd,
  output logic                  in_ready
);
  dsp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= dsp_pkg::S_LOAD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = dsp_pkg::C_NONE;
    in_ready = 1'b0;
    case (state)
      dsp_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd = dsp_pkg::C_LOAD;
          if (status.load_done) state_next = dsp_pkg::S_INIT;
        end
      end
      dsp_pkg::S_INIT: begin
        cmd = dsp_pkg::C_INIT;
        state_next = dsp_pkg::S_CLR;
      end
      dsp_pkg::S_CLR: begin
        // try next root in ascending order
        cmd = dsp_pkg::C_CLR;
        if (status.clr_done) state_next = dsp_pkg::S_REL_POP;
        else state_next = dsp_pkg::S_DFS_TOP;
      end
      dsp_pkg::S_DFS_TOP: begin
        cmd = dsp_pkg::C_DFS_TOP;
        if (status.sp_empty) state_next = dsp_pkg::S_CLR;
        else if (status.frame_done) state_next = dsp_pkg::S_DFS_TOP;
        else state_next = dsp_pkg::S_DFS_RD;
      end
      dsp_pkg::S_DFS_RD: begin
        cmd = dsp_pkg::C_DFS_RD;
        state_next = dsp_pkg::S_DFS_EVAL;
      end
      dsp_pkg::S_DFS_EVAL: begin
        cmd = dsp_pkg::C_DFS_EVAL;
        state_next = dsp_pkg::S_DFS_TOP;
      end
      dsp_pkg::S_REL_POP: begin
        cmd = dsp_pkg::C_REL_POP;
        if (status.order_empty) state_next = dsp_pkg::S_EMIT;
        else if (status.cur_reach) state_next = dsp_pkg::S_REL_RD;
      end
      dsp_pkg::S_REL_RD: begin
        cmd = dsp_pkg::C_REL_RD;
        state_next = dsp_pkg::S_REL_EVAL;
      end
      dsp_pkg::S_REL_EVAL: begin
        cmd = dsp_pkg::C_REL_EVAL;
        if (status.col_done) state_next = dsp_pkg::S_REL_POP;
        else state_next = dsp_pkg::S_REL_RD;
      end
      dsp_pkg::S_EMIT: begin
        if (!status.out_full) begin
          cmd = dsp_pkg::C_EMIT;
          if (status.emit_done) state_next = dsp_pkg::S_LOAD;
        end
      end
      default: state_next = dsp_pkg::S_LOAD;
    endcase
  end
endmodule
`default_nettype wire

[hdl/dsp_datapath.sv]
// Datapath: weight memory, search and order stacks, distances, result register.
// Depends on dsp_pkg; commanded by dsp_ctrl.
`default_nettype none
module dsp_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dsp_pkg::cmd_t                       cmd,
  output dsp_pkg::status_t                         status,
  input  wire logic signed [dsp_pkg::WeightBits-1:0] in_weight,
  input  wire logic                                cfg_we_count,
  input  wire logic                                cfg_we_source,
  input  wire logic [4:0]                          cfg_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [3:0]                               out_vertex,
  output logic signed [23:0]                       out_distance,
  output logic                                     out_reach,
  output logic                                     out_last
);
  localparam int VB = dsp_pkg::VBits;
  localparam int CB = dsp_pkg::CntBits;
  localparam int AB = dsp_pkg::AddrBits;
  localparam int DB = dsp_pkg::DistBits;
  localparam int MV = dsp_pkg::MaxVertices;
  localparam logic signed [DB:0] DMax = (DB+1)'(8388607);
  localparam logic signed [DB:0] DMin = -(DB+1)'(8388608);

  logic [4:0] vcount_reg;
  logic [3:0] source_reg;
  logic [CB-1:0] n;
  logic [AB:0] total;

  logic signed [dsp_pkg::WeightBits-1:0] wmem [MV*MV];
  logic signed [dsp_pkg::WeightBits-1:0] rd_w;
  logic [VB-1:0] row, col;
  logic [AB:0] load_cnt;

  logic [MV-1:0] visited, reach;
  logic [VB-1:0] sstk_v [MV];
  logic [CB-1:0] sstk_c [MV];
  logic [CB-1:0] sp;
  logic [VB-1:0] ostk [MV];
  logic [CB-1:0] otop;
  logic [CB-1:0] root;
  logic signed [DB-1:0] best [MV];
  logic signed [DB-1:0] cur_dist;
  logic [VB-1:0] cur;
  logic [CB-1:0] rcol;
  logic [CB-1:0] emit_idx;
  logic [VB-1:0] top_v;
  logic [CB-1:0] top_c;
  logic signed [DB:0] sum;
  logic signed [DB-1:0] nd;
  logic [VB-1:0] clamp_src;

  always_comb begin
    if (vcount_reg == 5'd0) n = CB'(1);
    else if (vcount_reg > 5'(MV)) n = CB'(MV);
    else n = vcount_reg[CB-1:0];
    total = (AB+1)'(n) * (AB+1)'(n);
    top_v = sstk_v[sp[VB-1:0] - VB'(1)];
    top_c = sstk_c[sp[VB-1:0] - VB'(1)];
    sum = (DB+1)'(cur_dist) + (DB+1)'(rd_w);
    if (sum > DMax) nd = DMax[DB-1:0];
    else if (sum < DMin) nd = DMin[DB-1:0];
    else nd = sum[DB-1:0];
    clamp_src = source_reg;
  end

  always_comb begin
    status.load_done   = (load_cnt + (AB+1)'(1)) >= total;
    status.clr_done    = root >= n;
    status.sp_empty    = sp == '0;
    status.frame_done  = top_c == '0;
    status.order_empty = otop == '0;
    status.cur_reach   = (otop != '0) && reach[ostk[otop[VB-1:0] - VB'(1)]];
    status.col_done    = rcol == '0;
    status.emit_done   = emit_idx + CB'(1) == n;
    status.out_full    = out_valid && !out_ready;
  end

  // weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd == dsp_pkg::C_LOAD) wmem[{row, col}] <= in_weight;
    rd_w <= wmem[{row, col}];
  end

  always_ff @(posedge clk) begin
    if (cmd == dsp_pkg::C_EMIT) begin
      out_vertex   <= emit_idx[VB-1:0];
      out_distance <= reach[emit_idx[VB-1:0]] ? best[emit_idx[VB-1:0]] : '0;
      out_reach    <= reach[emit_idx[VB-1:0]];
      out_last     <= status.emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount_reg <= 5'd16;
      source_reg <= '0;
      load_cnt <= '0;
      row <= '0;
      col <= '0;
      visited <= '0;
      reach <= '0;
      sp <= '0;
      otop <= '0;
      root <= '0;
      rcol <= '0;
      emit_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we_source) source_reg <= cfg_data[3:0];
      if (cfg_we_count) begin
        vcount_reg <= cfg_data;
        load_cnt <= '0;
        row <= '0;
        col <= '0;
      end
      case (cmd)
        dsp_pkg::C_LOAD: begin
          if (status.load_done) begin
            load_cnt <= '0;
            row <= '0;
            col <= '0;
          end else begin
            load_cnt <= load_cnt + (AB+1)'(1);
            if (CB'(col) + CB'(1) == n) begin
              col <= '0;
              row <= row + VB'(1);
            end else col <= col + VB'(1);
          end
        end
        dsp_pkg::C_INIT: begin
          visited <= '0;
          reach <= '0;
          sp <= '0;
          otop <= '0;
          root <= '0;
        end
        dsp_pkg::C_CLR: begin
          if (root < n) begin
            if (!visited[root[VB-1:0]]) begin
              visited[root[VB-1:0]] <= 1'b1;
              sstk_v[0] <= root[VB-1:0];
              sstk_c[0] <= n;
              sp <= CB'(1);
            end
            root <= root + CB'(1);
          end else if ({1'b0, source_reg} < 5'(n)) begin
            reach[clamp_src] <= 1'b1;
            best[clamp_src] <= '0;
          end
        end
        dsp_pkg::C_DFS_TOP: begin
          if (sp != '0) begin
            if (top_c == '0) begin
              ostk[otop[VB-1:0]] <= top_v;
              otop <= otop + CB'(1);
              sp <= sp - CB'(1);
            end else begin
              row <= top_v;
              col <= VB'(top_c - CB'(1));
              sstk_c[sp[VB-1:0] - VB'(1)] <= top_c - CB'(1);
            end
          end
        end
        dsp_pkg::C_DFS_EVAL: begin
          if (rd_w != '0 && !visited[col]) begin
            visited[col] <= 1'b1;
            sstk_v[sp[VB-1:0]] <= col;
            sstk_c[sp[VB-1:0]] <= n;
            sp <= sp + CB'(1);
          end
        end
        dsp_pkg::C_REL_POP: begin
          if (otop != '0) begin
            cur <= ostk[otop[VB-1:0] - VB'(1)];
            cur_dist <= best[ostk[otop[VB-1:0] - VB'(1)]];
            otop <= otop - CB'(1);
            rcol <= n;
            // address of the highest column, read during the next state
            row <= ostk[otop[VB-1:0] - VB'(1)];
            col <= VB'(n - CB'(1));
          end
        end
        dsp_pkg::C_REL_RD: begin
          rcol <= rcol - CB'(1);
        end
        dsp_pkg::C_REL_EVAL: begin
          if (rd_w != '0 && (!reach[col] || best[col] > nd)) begin
            best[col] <= nd;
            reach[col] <= 1'b1;
          end
          if (rcol != '0) col <= col - VB'(1);
        end
        dsp_pkg::C_EMIT: begin
          out_valid <= 1'b1;
          emit_idx <= status.emit_done ? '0 : emit_idx + CB'(1);
          row <= '0;
          col <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/dag_shortest_path.sv]
// Shortest paths on a loaded DAG: one weight word per cycle while loading.
// After the last word come the DFS ordering and the relaxation, then N result
// words, one per cycle when not stalled.
// Sequential: one matrix at a time; loading stalls while results are produced.
// Synchronous active-high reset: vertex count 16, source 0, load restarts.
`default_nettype none
module dag_shortest_path (
  input wire logic clk,
  input wire logic rst,
  dsp_in_if.sink   in_ch,
  dsp_out_if.source out_ch,
  dsp_cfg_if.sink  cfg
);
  dsp_pkg::cmd_t    cmd;
  dsp_pkg::status_t status;
  logic             in_ready;

  assign in_ch.ready = in_ready;
  assign cfg.ready   = 1'b1;

  dsp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_ch.valid && in_ready),
    .status(status), .cmd(cmd), .in_ready(in_ready)
  );

  dsp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_weight(in_ch.edge_weight),
    .cfg_we_count(cfg.valid && cfg.index == 1'(dsp_pkg::RegVertexCount)),
    .cfg_we_source(cfg.valid && cfg.index == 1'(dsp_pkg::RegSourceVertex)),
    .cfg_data(cfg.data),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_vertex(out_ch.vertex_index), .out_distance(out_ch.distance),
    .out_reach(out_ch.reachable), .out_last(out_ch.last_result)
  );
endmodule
`default_nettype wire

[hdl/dsp_checker.sv]
// Port-level checker for dag_shortest_path, bound to the top level.
// Depends on dag_shortest_path_defines.svh.
`default_nettype none
`include "dag_shortest_path_defines.svh"
module dsp_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_reach,
  input wire logic signed [23:0] out_distance
);
  `DSP_ASSERT_NEXT(a_stable, out_valid && !out_ready, $stable(out_distance) && $stable(out_reach), "result word changed while stalled")
  `DSP_ASSERT_IMP(a_unreach_zero, out_valid && !out_reach, out_distance == '0, "unreachable nonzero")
  `DSP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result word dropped")
endmodule

bind dag_shortest_path dsp_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_reach(out_ch.reachable), .out_distance(out_ch.distance)
);
`default_nettype wire

[verif/tb_dag_shortest_path.sv]
// Self-checking bench for dag_shortest_path: loads weight matrices, predicts
// per-vertex distances and compares every result word. Depends on dsp_pkg, dsp_if.
`default_nettype none
module tb_dag_shortest_path;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [3:0]         vi;
    logic signed [23:0] dval;
    logic               reach;
    logic               last;
  } dist_word_t;

  typedef struct packed {
    logic               is_cfg;
    logic [0:0]         idx;
    logic [4:0]         data;
    logic signed [15:0] w;
    logic               typed;
    dist_word_t         want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dsp_in_if  in_ch (clk);
  dsp_out_if out_ch (clk);
  dsp_cfg_if cfg (clk);

  dag_shortest_path DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

  // predictor state
  logic signed [15:0] wmat [16][16];
  int                 load_pos;
  logic [4:0]         vcount_reg;
  logic [3:0]         src_reg;
  dist_word_t         dist_q [$];

  int  cycles;
  int  mismatches;
  bit  hold_go;
  int  items_sent;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  function automatic bit quiet();
    return cycles > 2000 && cycles < 4000;
  endfunction

  function automatic void predict_word(logic signed [15:0] w);
    int n, total, i, j, sp, otop, cur;
    int stk_v [16];
    int stk_c [16];
    int order [16];
    bit vis [16];
    bit rch [16];
    longint bd [16];
    longint nd;
    dist_word_t r;
    n = vcount_reg;
    if (n < 1) n = 1;
    if (n > dsp_pkg::MaxVertices) n = dsp_pkg::MaxVertices;
    total = n * n;
    if (load_pos >= total) load_pos = 0;
    wmat[load_pos / n][load_pos % n] = w;
    load_pos++;
    if (load_pos < total) return;
    for (i = 0; i < 16; i++) begin
      vis[i] = 0; rch[i] = 0; bd[i] = 0;
    end
    otop = 0;
    // depth-first ordering, roots ascending, columns descending
    for (i = 0; i < n; i++) begin
      if (!vis[i]) begin
        vis[i] = 1; stk_v[0] = i; stk_c[0] = n - 1; sp = 1;
        while (sp > 0) begin
          if (stk_c[sp-1] < 0) begin
            if (otop < 16) begin
              order[otop] = stk_v[sp-1];
              otop++;
            end
            sp--;
          end else begin
            j = stk_c[sp-1];
            stk_c[sp-1]--;
            if (wmat[stk_v[sp-1]][j] != 0 && !vis[j] && sp < 16) begin
              vis[j] = 1; stk_v[sp] = j; stk_c[sp] = n - 1; sp++;
            end
          end
        end
      end
    end
    if (src_reg < n) rch[src_reg] = 1;
    while (otop > 0) begin
      otop--;
      cur = order[otop];
      if (rch[cur]) begin
        for (j = n - 1; j >= 0; j--) begin
          if (wmat[cur][j] != 0) begin
            nd = bd[cur] + longint'(wmat[cur][j]);
            if (nd > 64'sd8388607) nd = 64'sd8388607;
            if (nd < -64'sd8388608) nd = -64'sd8388608;
            if (!rch[j] || bd[j] > nd) begin
              bd[j] = nd; rch[j] = 1;
            end
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      r.vi = 4'(i);
      r.dval = rch[i] ? 24'(bd[i]) : 24'sd0;
      r.reach = rch[i];
      r.last = (i + 1 == n);
      dist_q.push_back(r);
    end
    load_pos = 0;
  endfunction

  task automatic send_weight(logic signed [15:0] w);
    @(negedge clk);
    while (!quiet() && $urandom_range(0, 99) < 15) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.edge_weight = w;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(w);
    items_sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] data);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (dist_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == 1'(dsp_pkg::RegVertexCount)) begin
      vcount_reg = data;
      load_pos = 0;
    end else begin
      src_reg = data[3:0];
    end
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  function automatic logic signed [15:0] pick_weight(bit dag_form, int row, int col);
    if (dag_form && col <= row) return 16'sd0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'sd0;
      4, 5, 6:    return $signed(16'($urandom_range(0, 40))) - 16'sd20;
      7, 8:       return 16'($urandom);
      default:    return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // result receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (400) begin
          out_ch.ready = 1'b0;
          @(negedge clk);
        end
      end
      out_ch.ready = quiet() || $urandom_range(0, 99) >= 15;
    end
  end

  always @(posedge clk) begin
    dist_word_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.vertex_index, out_ch.distance, out_ch.reachable, out_ch.last_result};
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", got);
      end else begin
        want = dist_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    int n, phase, k;
    bit dag_form, hold_done;
    cycles = 0; mismatches = 0; hold_go = 0; items_sent = 0;
    in_ch.valid = 1'b0; in_ch.edge_weight = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    load_pos = 0; vcount_reg = 5'd16; src_reg = 4'd0;
    for (int r = 0; r < 16; r++) for (int c = 0; c < 16; c++) wmat[r][c] = '0;

    // single vertex, self-loop of max weight: still distance 0 from itself
    rows.push_back('{1'b1, 1'(dsp_pkg::RegVertexCount), 5'd1, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b1, 1'(dsp_pkg::RegSourceVertex), 5'd0, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sh7fff, 1'b1, '{4'd0, 24'sd0, 1'b1, 1'b1}});
    // source beyond vertex count: nothing reachable
    rows.push_back('{1'b1, 1'(dsp_pkg::RegSourceVertex), 5'd15, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sh8000, 1'b1, '{4'd0, 24'sd0, 1'b0, 1'b1}});
    // vertex count of zero acts as one
    rows.push_back('{1'b1, 1'(dsp_pkg::RegVertexCount), 5'd0, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b1, 1'(dsp_pkg::RegSourceVertex), 5'd0, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sd1, 1'b1, '{4'd0, 24'sd0, 1'b1, 1'b1}});
    // two vertices, extreme weights
    rows.push_back('{1'b1, 1'(dsp_pkg::RegVertexCount), 5'd2, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sh7fff, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sh8000, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sd0, 1'b0, '0});
    // count rewritten mid-load restarts the matrix
    rows.push_back('{1'b1, 1'(dsp_pkg::RegVertexCount), 5'd3, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sd5, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sd5, 1'b0, '0});
    rows.push_back('{1'b1, 1'(dsp_pkg::RegVertexCount), 5'd2, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b1, 1'(dsp_pkg::RegSourceVertex), 5'd1, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sd0, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sh8000, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, -16'sd7, 1'b0, '0});
    rows.push_back('{1'b0, 1'b0, 5'd0, 16'sd3, 1'b0, '0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.is_cfg) begin
        write_reg(rw.idx, rw.data);
      end else begin
        send_weight(rw.w);
        if (rw.typed) begin
          void'(dist_q.pop_back());
          dist_q.push_back(rw.want);
        end
      end
    end

    // random phases; one oversized count clamps to the full matrix
    items_sent = 0;
    hold_done = 0;
    phase = 0;
    while (items_sent < 270 || phase < 4) begin
      if (phase == 1) begin
        write_reg(1'(dsp_pkg::RegVertexCount), 5'd20);
        write_reg(1'(dsp_pkg::RegSourceVertex), 5'($urandom_range(0, 15)));
      end else if (phase % 3 != 0) begin
        write_reg(1'(dsp_pkg::RegVertexCount), 5'($urandom_range(0, 8)));
        write_reg(1'(dsp_pkg::RegSourceVertex), 5'($urandom_range(0, 15)));
      end
      n = vcount_reg == 0 ? 1 : (vcount_reg > 16 ? 16 : int'(vcount_reg));
      dag_form = $urandom_range(0, 99) < 80;
      if (!hold_done && phase % 3 == 2) begin
        hold_go = 1'b1;
        hold_done = 1;
      end
      for (k = 0; k < n * n; k++) send_weight(pick_weight(dag_form, k / n, k % n));
      phase++;
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/dsp_pkg.sv
hdl/dsp_if.sv
hdl/dsp_ctrl.sv
hdl/dsp_datapath.sv
hdl/dag_shortest_path.sv
hdl/dsp_checker.sv
verif/tb_dag_shortest_path.sv
